FILE: sv/efp_pkg.sv
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, constants and codes for the fisher penalty engine.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int DIMS  = 16;
  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int CNT_W = $clog2(DIMS + 1);

  localparam int OP_W      = 3;
  localparam int IDX_IN_W  = 4;
  localparam int VAL_W     = 32;
  localparam int FIS_W     = 56;
  localparam int SUM_W     = 64;
  localparam int PEN_W     = 63;
  localparam int CNT_OUT_W = 5;
  localparam int LAM_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 56;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 96;
  localparam int ACC_W   = 128;

  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_ACCUM = 3'd2;
  localparam logic [OP_W-1:0] OP_TERM  = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

  localparam logic [LAM_W-1:0] LAMBDA_RST = 32'd65536;
  localparam logic [FIS_W-1:0] THRESH_RST = 56'd65536;
  localparam logic [FIS_W-1:0] ONE_Q16    = 56'd65536;
  // 1e12 in q40.16
  localparam logic [FIS_W-1:0] FISHER_CLAMP = 56'd65536000000000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_GG,
    ST_DD,
    ST_FT,
    ST_LSGO,
    ST_LS,
    ST_WALK,
    ST_FIN
  } efp_state_t;

  typedef enum logic [1:0] {
    MS_GG,
    MS_DD,
    MS_FT,
    MS_LS
  } efp_msel_t;

  typedef struct packed {
    logic      ld_item;
    logic      rd_walk;
    logic      cap_rd;
    logic      clear;
    logic      anchor_wr;
    logic      mul_start;
    efp_msel_t mul_sel;
    logic      fisher_acc;
    logic      term_add;
    logic      finish;
    logic      sum_zero;
    logic      walk_start;
    logic      walk_en;
    logic      load_out;
  } efp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            init;
    logic            in_range;
    logic            last;
    logic            mul_done;
    logic            walk_done;
  } efp_sts_t;

endpackage

FILE: sv/ewc_fisher_penalty_engine_unit.sv
// ----------------------------------------------------------------------------
// ewc_fisher_penalty_engine_unit
// A penalty term that closes a run also scales the sum by lambda; a count
//   query walks the whole table.
// Throughput: one item at a time, set by the shared 32x32 partial-product
//   multiplier and the single table read port; a finished item may wait in the
//   output register while the next one is taken. Sync reset clears control,
//   table valid bits, sum and config; tables read as zero until written.
// ----------------------------------------------------------------------------
module ewc_fisher_penalty_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [efp_pkg::OP_W-1:0]          opcode,
  input  logic [efp_pkg::IDX_IN_W-1:0]      dim,
  input  logic signed [efp_pkg::VAL_W-1:0]  value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic [efp_pkg::PEN_W-1:0]         penalty,
  output logic                              penalty_valid,
  output logic                              dim_stable,
  output logic [efp_pkg::CNT_OUT_W-1:0]     stable_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [efp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [efp_pkg::CFG_DAT_W-1:0]     cfg_data
);

  efp_pkg::efp_cmd_t cmd;
  efp_pkg::efp_sts_t sts;

  assign cfg_ready = 1'b1;

  efp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  efp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .dim           (dim),
    .value         (value),
    .last          (last),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .penalty       (penalty),
    .penalty_valid (penalty_valid),
    .dim_stable    (dim_stable),
    .stable_count  (stable_count)
  );

endmodule

FILE: sv/efp_ram.sv
// ----------------------------------------------------------------------------
// efp_ram
// Generic single write port ram with registered read.
// ----------------------------------------------------------------------------
module efp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/efp_mul.sv
// ----------------------------------------------------------------------------
// efp_mul
// Multi-cycle multiplier: one 32x32 partial product per cycle, registered,
// then shifted into a 128-bit accumulator.
// ----------------------------------------------------------------------------
module efp_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [efp_pkg::MUL_A_W-1:0] a,
  input  logic [efp_pkg::MUL_B_W-1:0] b,
  input  logic                        na,
  input  logic [1:0]                  nb,
  output logic [efp_pkg::ACC_W-1:0]   acc,
  output logic                        done
);

  logic [efp_pkg::MUL_A_W-1:0] a_r;
  logic [efp_pkg::MUL_B_W-1:0] b_r;
  logic                        na_r;
  logic [1:0]                  nb_r;
  logic                        i_r;
  logic [1:0]                  j_r;
  logic                        iss;
  logic                        pv;
  logic                        last_r;
  logic [1:0]                  sh_r;
  logic [63:0]                 prod_r;
  logic [31:0]                 a_l;
  logic [31:0]                 b_l;
  logic [efp_pkg::ACC_W-1:0]   addend;

  assign a_l = i_r ? a_r[63:32] : a_r[31:0];

  always_comb begin
    unique case (j_r)
      2'd0:    b_l = b_r[31:0];
      2'd1:    b_l = b_r[63:32];
      2'd2:    b_l = b_r[95:64];
      default: b_l = '0;
    endcase
  end

  always_comb begin
    unique case (sh_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd1:    addend = {32'd0, prod_r, 32'd0};
      2'd2:    addend = {prod_r, 64'd0};
      // only the small top limbs land here, the upper half is zero
      default: addend = {prod_r[31:0], 96'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss  <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      iss  <= 1'b1;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      pv   <= iss;
      done <= pv && last_r;
      if (iss && (j_r == nb_r) && (i_r == na_r)) begin
        iss <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      na_r <= na;
      nb_r <= nb;
      i_r  <= 1'b0;
      j_r  <= 2'd0;
      acc  <= '0;
    end else begin
      if (iss) begin
        prod_r <= {32'd0, a_l} * {32'd0, b_l};
        sh_r   <= {1'b0, i_r} + j_r;
        last_r <= (i_r == na_r) && (j_r == nb_r);
        if (j_r == nb_r) begin
          j_r <= 2'd0;
          i_r <= ~i_r;
        end else begin
          j_r <= j_r + 2'd1;
        end
      end
      if (pv) begin
        acc <= acc + addend;
      end
    end
  end

endmodule

FILE: sv/efp_dp.sv
// ----------------------------------------------------------------------------
// efp_dp
// Datapath: anchor and fisher tables, running sum, config registers,
// multiplier, stable count walk and the output register.
// ----------------------------------------------------------------------------
module efp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  efp_pkg::efp_cmd_t               cmd,
  output efp_pkg::efp_sts_t               sts,
  input  logic [efp_pkg::OP_W-1:0]        opcode,
  input  logic [efp_pkg::IDX_IN_W-1:0]    dim,
  input  logic signed [efp_pkg::VAL_W-1:0] value,
  input  logic                            last,
  input  logic                            cfg_we,
  input  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efp_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic                            status,
  output logic [efp_pkg::PEN_W-1:0]       penalty,
  output logic                            penalty_valid,
  output logic                            dim_stable,
  output logic [efp_pkg::CNT_OUT_W-1:0]   stable_count
);

  localparam int DIM_W = efp_pkg::DIM_W;
  localparam int DIMS  = efp_pkg::DIMS;
  localparam int CNT_W = efp_pkg::CNT_W;

  // item registers
  logic [efp_pkg::OP_W-1:0]  op_r;
  logic [DIM_W-1:0]          idx_r;
  logic                      rng_r;
  logic [efp_pkg::VAL_W-1:0] val_r;
  logic                      last_r;

  logic [efp_pkg::LAM_W-1:0] lambda_gain;
  logic [efp_pkg::FIS_W-1:0] count_threshold;
  logic                      init;
  logic [efp_pkg::SUM_W-1:0] sum;
  logic [DIMS-1:0]           vld_a;
  logic [DIMS-1:0]           vld_f;

  logic [DIM_W-1:0]          rd_addr;
  logic [DIM_W-1:0]          rd_addr_q;
  logic [efp_pkg::VAL_W-1:0] a_q;
  logic [efp_pkg::FIS_W-1:0] f_q;
  logic [efp_pkg::VAL_W-1:0] anchor_rd;
  logic [efp_pkg::FIS_W-1:0] fisher_rd;
  logic [efp_pkg::FIS_W-1:0] f_cur;

  logic [CNT_W-1:0]          wcnt;
  logic                      cmp_v;

  logic                      res_status;
  logic [efp_pkg::PEN_W-1:0] res_pen;
  logic                      res_pvalid;
  logic                      res_stable;
  logic [CNT_W-1:0]          res_cnt;

  logic [efp_pkg::MUL_A_W-1:0] mul_a;
  logic [efp_pkg::MUL_B_W-1:0] mul_b;
  logic                        mul_na;
  logic [1:0]                  mul_nb;
  logic [efp_pkg::ACC_W-1:0]   mul_acc;
  logic                        mul_done;

  logic [efp_pkg::VAL_W-1:0]   g_mag;
  logic [efp_pkg::VAL_W:0]     diff;
  logic [efp_pkg::VAL_W:0]     d_mag;
  logic [efp_pkg::FIS_W:0]     f_sum;
  logic [efp_pkg::FIS_W-1:0]   f_new;
  logic [efp_pkg::SUM_W-1:0]   term;
  logic [efp_pkg::SUM_W:0]     sum_add;
  logic [efp_pkg::PEN_W-1:0]   pen_val;
  logic                        in_rng;

  assign in_rng = {28'd0, dim} < 32'(DIMS);

  assign sts.op        = op_r;
  assign sts.init      = init;
  assign sts.in_range  = rng_r;
  assign sts.last      = last_r;
  assign sts.mul_done  = mul_done;
  assign sts.walk_done = (wcnt == CNT_W'(DIMS)) && !cmp_v;

  assign rd_addr   = cmd.rd_walk ? DIM_W'(wcnt) : DIM_W'(dim);
  assign anchor_rd = vld_a[rd_addr_q] ? a_q : '0;
  assign fisher_rd = vld_f[rd_addr_q] ? f_q : '0;

  efp_ram #(.WIDTH(efp_pkg::VAL_W), .DEPTH(DIMS)) u_anchor_ram (
    .clk   (clk),
    .we    (cmd.anchor_wr),
    .waddr (idx_r),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (a_q)
  );

  efp_ram #(.WIDTH(efp_pkg::FIS_W), .DEPTH(DIMS)) u_fisher_ram (
    .clk   (clk),
    .we    (cmd.fisher_acc),
    .waddr (idx_r),
    .wdata (f_new),
    .raddr (rd_addr),
    .rdata (f_q)
  );

  // magnitudes; the sign drops out of the square
  assign g_mag = val_r[efp_pkg::VAL_W-1] ? (~val_r + 32'd1) : val_r;
  assign diff  = {val_r[efp_pkg::VAL_W-1], val_r} - {anchor_rd[efp_pkg::VAL_W-1], anchor_rd};
  assign d_mag = diff[efp_pkg::VAL_W] ? (~diff + 33'd1) : diff;

  always_comb begin
    unique case (cmd.mul_sel)
      efp_pkg::MS_GG: begin
        mul_a  = {32'd0, g_mag};
        mul_b  = {64'd0, g_mag};
        mul_na = 1'b0;
        mul_nb = 2'd0;
      end
      efp_pkg::MS_DD: begin
        mul_a  = {31'd0, d_mag};
        mul_b  = {63'd0, d_mag};
        mul_na = 1'b1;
        mul_nb = 2'd1;
      end
      efp_pkg::MS_FT: begin
        mul_a  = {8'd0, f_cur};
        mul_b  = {31'd0, mul_acc[64:0]};
        mul_na = 1'b1;
        mul_nb = 2'd2;
      end
      default: begin
        mul_a  = {32'd0, lambda_gain};
        mul_b  = {32'd0, sum};
        mul_na = 1'b0;
        mul_nb = 2'd1;
      end
    endcase
  end

  efp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .na    (mul_na),
    .nb    (mul_nb),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  // g*g is q32.32, back to q40.16 before the add
  assign f_sum = {1'b0, f_cur} + {10'd0, mul_acc[62:16]};
  assign f_new = (f_sum > {1'b0, efp_pkg::FISHER_CLAMP}) ? efp_pkg::FISHER_CLAMP
                                                        : f_sum[efp_pkg::FIS_W-1:0];

  assign term    = (mul_acc[127:96] != '0) ? '1 : mul_acc[95:32];
  assign sum_add = {1'b0, sum} + {1'b0, term};
  assign pen_val = (mul_acc[127:79] != '0) ? '1 : mul_acc[78:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_gain     <= efp_pkg::LAMBDA_RST;
      count_threshold <= efp_pkg::THRESH_RST;
    end else if (cfg_we) begin
      if (cfg_index == efp_pkg::CFG_LAMBDA) begin
        lambda_gain <= cfg_data[efp_pkg::LAM_W-1:0];
      end else if (cfg_index == efp_pkg::CFG_THRESH) begin
        count_threshold <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init  <= 1'b0;
      sum   <= '0;
      vld_a <= '0;
      vld_f <= '0;
      wcnt  <= '0;
      cmp_v <= 1'b0;
    end else begin
      if (cmd.clear) begin
        init  <= 1'b1;
        sum   <= '0;
        vld_a <= '0;
        vld_f <= '0;
      end
      if (cmd.anchor_wr) begin
        vld_a[idx_r] <= 1'b1;
      end
      if (cmd.fisher_acc) begin
        vld_f[idx_r] <= 1'b1;
      end
      if (cmd.term_add) begin
        sum <= sum_add[efp_pkg::SUM_W] ? '1 : sum_add[efp_pkg::SUM_W-1:0];
      end
      if (cmd.finish || cmd.sum_zero) begin
        sum <= '0;
      end
      if (cmd.walk_start) begin
        wcnt  <= '0;
        cmp_v <= 1'b0;
      end else if (cmd.walk_en) begin
        if (wcnt != CNT_W'(DIMS)) begin
          wcnt  <= wcnt + 1'b1;
          cmp_v <= 1'b1;
        end else begin
          cmp_v <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (cmd.ld_item) begin
      op_r   <= opcode;
      idx_r  <= DIM_W'(dim);
      rng_r  <= in_rng;
      val_r  <= value;
      last_r <= last;
    end
    if (cmd.cap_rd) begin
      f_cur      <= fisher_rd;
      res_status <= !init && ((op_r == efp_pkg::OP_LOAD) || (op_r == efp_pkg::OP_ACCUM) ||
                              (op_r == efp_pkg::OP_TERM));
      res_pvalid <= (op_r == efp_pkg::OP_TERM) && last_r;
      res_pen    <= '0;
      // a start item empties the table, so nothing is stable after it
      res_stable <= rng_r && (op_r != efp_pkg::OP_START) &&
                    (fisher_rd >= efp_pkg::ONE_Q16);
      res_cnt    <= '0;
    end
    if (cmd.fisher_acc) begin
      res_stable <= f_new >= efp_pkg::ONE_Q16;
    end
    if (cmd.finish) begin
      res_pen <= pen_val;
    end
    if (cmd.walk_en && cmp_v && (fisher_rd >= count_threshold)) begin
      res_cnt <= res_cnt + 1'b1;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      penalty       <= res_pen;
      penalty_valid <= res_pvalid;
      dim_stable    <= res_stable;
      stable_count  <= efp_pkg::CNT_OUT_W'(res_cnt);
    end
  end

endmodule

FILE: sv/efp_ctrl.sv
// ----------------------------------------------------------------------------
// efp_ctrl
// Controller: sequences each item through read, multiply steps, count walk
// and the output register handshake.
// ----------------------------------------------------------------------------
module efp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  efp_pkg::efp_sts_t sts,
  output efp_pkg::efp_cmd_t cmd
);

  efp_pkg::efp_state_t state;
  efp_pkg::efp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= efp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != efp_pkg::ST_IDLE);
    unique case (state)
      efp_pkg::ST_IDLE: begin
        cmd.ld_item = in_valid;
        if (in_valid) begin
          state_next = efp_pkg::ST_READ;
        end
      end
      efp_pkg::ST_READ: begin
        cmd.cap_rd = 1'b1;
        state_next = efp_pkg::ST_FIN;
        unique case (sts.op)
          efp_pkg::OP_START: begin
            cmd.clear = 1'b1;
          end
          efp_pkg::OP_LOAD: begin
            cmd.anchor_wr = sts.init && sts.in_range;
          end
          efp_pkg::OP_ACCUM: begin
            if (sts.init && sts.in_range) begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel   = efp_pkg::MS_GG;
              state_next    = efp_pkg::ST_GG;
            end
          end
          efp_pkg::OP_TERM: begin
            if (!sts.init) begin
              cmd.sum_zero = sts.last;
            end else if (sts.in_range) begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel   = efp_pkg::MS_DD;
              state_next    = efp_pkg::ST_DD;
            end else if (sts.last) begin
              state_next = efp_pkg::ST_LSGO;
            end
          end
          efp_pkg::OP_COUNT: begin
            cmd.walk_start = 1'b1;
            state_next     = efp_pkg::ST_WALK;
          end
          default: begin
          end
        endcase
      end
      efp_pkg::ST_GG: begin
        if (sts.mul_done) begin
          cmd.fisher_acc = 1'b1;
          state_next     = efp_pkg::ST_FIN;
        end
      end
      efp_pkg::ST_DD: begin
        if (sts.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = efp_pkg::MS_FT;
          state_next    = efp_pkg::ST_FT;
        end
      end
      efp_pkg::ST_FT: begin
        if (sts.mul_done) begin
          cmd.term_add = 1'b1;
          state_next   = sts.last ? efp_pkg::ST_LSGO : efp_pkg::ST_FIN;
        end
      end
      efp_pkg::ST_LSGO: begin
        // sum is settled now, scale it by lambda
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = efp_pkg::MS_LS;
        state_next    = efp_pkg::ST_LS;
      end
      efp_pkg::ST_LS: begin
        cmd.mul_sel = efp_pkg::MS_LS;
        if (sts.mul_done) begin
          cmd.finish = 1'b1;
          state_next = efp_pkg::ST_FIN;
        end
      end
      efp_pkg::ST_WALK: begin
        cmd.rd_walk = 1'b1;
        cmd.walk_en = 1'b1;
        if (sts.walk_done) begin
          state_next = efp_pkg::ST_FIN;
        end
      end
      efp_pkg::ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = efp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = efp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/tb_ewc_fisher_penalty_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_ewc_fisher_penalty_engine_unit
// Self-checking bench for the fisher penalty engine. A directed table covers
// the uninitialized path, unused opcodes, field extremes, the 1.0 stability
// boundary and penalty saturation. A heavy phase builds one large fisher
// entry from extreme gradients and runs terms against it. Random phases then
// run under several gain and threshold settings.
// Every result is compared with an in-bench prediction of the engine, while
// both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ewc_fisher_penalty_engine_unit;
  import efp_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam int CYCLE_LIMIT      = 1000000;
  localparam int END_SETTLE       = 40;
  localparam int HEAVY_ITEMS      = 16;
  localparam int RANDOM_PER_PHASE = 57;
  localparam int NUM_PHASES       = 6;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [IDX_IN_W-1:0] dim;
    logic [VAL_W-1:0]    val;
    logic                last_term;
  } efp_item_t;

  typedef struct packed {
    logic                 status;
    logic [PEN_W-1:0]     penalty;
    logic                 pvalid;
    logic                 stable;
    logic [CNT_OUT_W-1:0] count;
  } efp_result_t;

  typedef struct packed {
    efp_item_t   item;
    logic        typed;
    efp_result_t want;
  } stim_row_t;

  typedef struct packed {
    efp_item_t   item;
    efp_result_t want;
  } pending_t;

  localparam efp_result_t RES_QUIET      = '0;
  localparam efp_result_t RES_NOT_INIT   = '{status: 1'b1, default: '0};
  localparam efp_result_t RES_NOT_INIT_END = '{status: 1'b1, pvalid: 1'b1, default: '0};
  localparam efp_result_t RES_STABLE     = '{stable: 1'b1, default: '0};
  localparam efp_result_t RES_COUNT_ONE  = '{stable: 1'b1, count: 5'd1, default: '0};
  localparam efp_result_t RES_SAT_END    = '{penalty: '1, pvalid: 1'b1, default: '0};
  localparam efp_result_t RES_END_TWO    =
    '{penalty: 63'h2_0000, pvalid: 1'b1, stable: 1'b1, default: '0};

  localparam int NUM_ROWS = 24;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // not yet initialized
    '{'{OP_TERM,      4'd3,  32'h0005_0000, 1'b0}, 1'b1, RES_NOT_INIT},
    '{'{OP_LOAD,      4'd0,  32'hDEAD_BEEF, 1'b0}, 1'b1, RES_NOT_INIT},
    '{'{OP_ACCUM,     4'd5,  32'h7FFF_FFFF, 1'b0}, 1'b1, RES_NOT_INIT},
    '{'{OP_TERM,      4'd15, 32'h8000_0000, 1'b1}, 1'b1, RES_NOT_INIT_END},
    '{'{OP_COUNT,     4'd0,  32'h0000_0000, 1'b0}, 1'b1, RES_QUIET},
    '{'{OP_SPARE_LO,  4'd2,  32'h0000_0001, 1'b1}, 1'b1, RES_QUIET},
    '{'{OP_SPARE_HI,  4'd14, 32'h8000_0000, 1'b0}, 1'b1, RES_QUIET},
    '{'{OP_START,     4'd0,  32'h0000_0000, 1'b0}, 1'b1, RES_QUIET},
    // anchors at both extremes, fisher right at 1.0 then 2.0
    '{'{OP_LOAD,      4'd15, 32'h7FFF_FFFF, 1'b0}, 1'b1, RES_QUIET},
    '{'{OP_LOAD,      4'd0,  32'h8000_0000, 1'b0}, 1'b1, RES_QUIET},
    '{'{OP_ACCUM,     4'd1,  32'h0001_0000, 1'b0}, 1'b1, RES_STABLE},
    '{'{OP_ACCUM,     4'd1,  32'hFFFF_0000, 1'b1}, 1'b1, RES_STABLE},
    '{'{OP_COUNT,     4'd1,  32'h0000_0000, 1'b0}, 1'b1, RES_COUNT_ONE},
    '{'{OP_ACCUM,     4'd2,  32'h8000_0000, 1'b0}, 1'b0, RES_QUIET},
    '{'{OP_ACCUM,     4'd15, 32'h7FFF_FFFF, 1'b0}, 1'b0, RES_QUIET},
    // term saturation, sum saturation, saturated final penalty
    '{'{OP_TERM,      4'd1,  32'h0002_0000, 1'b0}, 1'b0, RES_QUIET},
    '{'{OP_TERM,      4'd2,  32'h8000_0000, 1'b0}, 1'b0, RES_QUIET},
    '{'{OP_TERM,      4'd15, 32'h8000_0000, 1'b0}, 1'b0, RES_QUIET},
    '{'{OP_TERM,      4'd4,  32'h1234_5678, 1'b1}, 1'b1, RES_SAT_END},
    // sum restarts from zero after a finished run
    '{'{OP_TERM,      4'd1,  32'h0001_0000, 1'b1}, 1'b1, RES_END_TWO},
    '{'{OP_ACCUM,     4'd3,  32'h0000_0000, 1'b1}, 1'b0, RES_QUIET},
    '{'{OP_START,     4'd8,  32'hFFFF_FFFF, 1'b1}, 1'b1, RES_QUIET},
    '{'{OP_COUNT,     4'd5,  32'h0000_0000, 1'b1}, 1'b1, RES_QUIET},
    '{'{OP_SPARE_MID, 4'd9,  32'hFFFF_FFFF, 1'b1}, 1'b1, RES_QUIET}
  };

  localparam logic [VAL_W-1:0] VAL_EDGES [6] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000
  };

  localparam logic [LAM_W-1:0] GAIN_SET [NUM_PHASES] = '{
    32'd0, 32'hFFFF_FFFF, LAMBDA_RST, 32'd1, 32'h0003_8000, 32'h0000_0400
  };
  localparam logic [FIS_W-1:0] THRESH_SET [NUM_PHASES] = '{
    56'd0, 56'hFF_FFFF_FFFF_FFFF, THRESH_RST, 56'd1,
    56'h00_0000_0004_0000, 56'h00_4000_0000_0000
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      opcode = '0;
  logic [IDX_IN_W-1:0]  dim = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 status;
  logic [PEN_W-1:0]     penalty;
  logic                 penalty_valid;
  logic                 dim_stable;
  logic [CNT_OUT_W-1:0] stable_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // engine state as seen by the bench
  logic [VAL_W-1:0] anchor_tab [DIMS];
  logic [FIS_W-1:0] fisher_tab [DIMS];
  logic             engine_live;
  logic [SUM_W-1:0] run_sum;
  logic [LAM_W-1:0] gain_reg;
  logic [FIS_W-1:0] thresh_reg;

  pending_t    pending_results [$];
  pending_t    head;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_hold = 0;
  int          free_run = 0;

  ewc_fisher_penalty_engine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .dim          (dim),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .penalty      (penalty),
    .penalty_valid(penalty_valid),
    .dim_stable   (dim_stable),
    .stable_count (stable_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic efp_result_t fisher_step(efp_item_t it);
    efp_result_t         r;
    logic signed [32:0]  diff;
    logic [32:0]         mag;
    logic [63:0]         sq;
    logic [127:0]        prod;
    logic [63:0]         grown;
    logic [63:0]         term;
    logic [64:0]         total;
    logic                in_range;
    r = '0;
    in_range = int'(it.dim) < DIMS;
    if (it.op == OP_START) begin
      for (int i = 0; i < DIMS; i++) begin
        anchor_tab[i] = '0;
        fisher_tab[i] = '0;
      end
      run_sum = '0;
      engine_live = 1'b1;
    end else if ((it.op == OP_LOAD || it.op == OP_ACCUM || it.op == OP_TERM) &&
                 !engine_live) begin
      r.status = 1'b1;
      if (it.op == OP_TERM && it.last_term) begin
        r.pvalid = 1'b1;
        run_sum = '0;
      end
    end else if (it.op == OP_LOAD) begin
      if (in_range) anchor_tab[it.dim] = it.val;
    end else if (it.op == OP_ACCUM) begin
      if (in_range) begin
        diff = $signed({it.val[VAL_W-1], it.val});
        mag = diff[32] ? 33'(-diff) : 33'(diff);
        sq = 64'(mag) * 64'(mag);
        grown = 64'(fisher_tab[it.dim]) + (sq >> 16);
        fisher_tab[it.dim] = (grown > 64'(FISHER_CLAMP)) ? FISHER_CLAMP : grown[FIS_W-1:0];
      end
    end else if (it.op == OP_TERM) begin
      if (in_range) begin
        diff = $signed({it.val[VAL_W-1], it.val}) -
               $signed({anchor_tab[it.dim][VAL_W-1], anchor_tab[it.dim]});
        mag = diff[32] ? 33'(-diff) : 33'(diff);
        sq = 64'(mag) * 64'(mag);
        prod = 128'(fisher_tab[it.dim]) * 128'(sq);
        term = (prod[127:96] != 0) ? '1 : prod[95:32];
        total = 65'(run_sum) + 65'(term);
        run_sum = total[64] ? '1 : total[63:0];
      end
      if (it.last_term) begin
        prod = 128'(gain_reg) * 128'(run_sum);
        r.penalty = (prod[127:79] != 0) ? '1 : prod[78:16];
        r.pvalid = 1'b1;
        run_sum = '0;
      end
    end else if (it.op == OP_COUNT) begin
      for (int i = 0; i < DIMS; i++) begin
        if (fisher_tab[i] >= thresh_reg) r.count = r.count + 1'b1;
      end
    end
    r.stable = in_range && (fisher_tab[it.dim] >= ONE_Q16);
    return r;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (free_run != 0) begin
      free_run--;
      return 0;
    end
    if (r < 5) begin
      free_run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value(logic [IDX_IN_W-1:0] d);
    int               r;
    logic [VAL_W-1:0] near;
    r = $urandom_range(0, 99);
    near = VAL_W'($urandom_range(0, 32'h0003_FFFF));
    if ($urandom_range(0, 1) == 1) near = -near;
    if (r < 25) return $urandom;
    if (r < 60) return near;
    // small distance from the stored anchor keeps terms unsaturated
    if (r < 85) return anchor_tab[d] + near;
    return VAL_EDGES[$urandom_range(0, 5)];
  endfunction

  function automatic efp_item_t random_item();
    efp_item_t it;
    int        r;
    r = $urandom_range(0, 99);
    it.dim = IDX_IN_W'($urandom_range(0, (1 << IDX_IN_W) - 1));
    it.last_term = 1'($urandom_range(0, 1));
    it.val = pick_value(it.dim);
    if (r < 4) begin
      it.op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
      it.val = $urandom;
    end else if (r < 7) begin
      it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end else if (r < 9) begin
      it.op = OP_START;
    end else if (r < 27) begin
      it.op = OP_LOAD;
    end else if (r < 52) begin
      it.op = OP_ACCUM;
    end else if (r < 90) begin
      it.op = OP_TERM;
      it.last_term = ($urandom_range(0, 4) == 0);
    end else begin
      it.op = OP_COUNT;
    end
    return it;
  endfunction

  task automatic drive_item(input efp_item_t it, input logic typed, input efp_result_t want);
    int          gap;
    efp_result_t r;
    pending_t    entry;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= it.op;
    dim      <= it.dim;
    value    <= it.val;
    last     <= it.last_term;
    do @(posedge clk); while (in_stall);
    r = fisher_step(it);
    entry.item = it;
    entry.want = typed ? want : r;
    pending_results.push_back(entry);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [LAM_W-1:0] gain, input logic [FIS_W-1:0] thr);
    logic                 gain_first;
    logic [CFG_DAT_W-1:0] gain_word;
    gain_first = 1'($urandom_range(0, 1));
    // junk above the gain width must be dropped
    gain_word = {(CFG_DAT_W - LAM_W)'($urandom), gain};
    cfg_valid <= 1'b1;
    cfg_index <= gain_first ? CFG_LAMBDA : CFG_THRESH;
    cfg_data  <= gain_first ? gain_word : thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= gain_first ? CFG_THRESH : CFG_LAMBDA;
    cfg_data  <= gain_first ? thr : gain_word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_reg = gain;
    thresh_reg = thr;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: status=%0d penalty=%h pvalid=%0d stable=%0d count=%0d",
                     status, penalty, penalty_valid, dim_stable, stable_count);
        end else begin
          head = pending_results.pop_front();
          if (status !== head.want.status || penalty !== head.want.penalty ||
              penalty_valid !== head.want.pvalid || dim_stable !== head.want.stable ||
              stable_count !== head.want.count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: op=%0d dim=%0d value=%h last=%0d",
                       head.item.op, head.item.dim, head.item.val, head.item.last_term);
              $display("  exp status=%0d penalty=%h pvalid=%0d stable=%0d count=%0d",
                       head.want.status, head.want.penalty, head.want.pvalid,
                       head.want.stable, head.want.count);
              $display("  got status=%0d penalty=%h pvalid=%0d stable=%0d count=%0d",
                       status, penalty, penalty_valid, dim_stable, stable_count);
            end
          end
        end
      end
      if (stall_hold != 0) begin
        stall_hold <= stall_hold - 1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 6);
          end
          4: begin
            out_stall  <= 1'b0;
            stall_hold <= $urandom_range(30, 120);
          end
          5, 6, 7, 8: begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(0, 3);
          end
          default: begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(10, 40);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ewc_fisher_penalty_engine_unit test failed");
      $finish;
    end
  end

  initial begin
    efp_item_t it;
    for (int i = 0; i < DIMS; i++) begin
      anchor_tab[i] = '0;
      fisher_tab[i] = '0;
    end
    engine_live = 1'b0;
    run_sum = '0;
    gain_reg = LAMBDA_RST;
    thresh_reg = THRESH_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++)
      drive_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    // build up one heavy entry from extreme gradients, then run terms against it
    drain();
    write_regs(32'hFFFF_FFFF, FISHER_CLAMP);
    drive_item('{OP_START, 4'd7, 32'h0, 1'b0}, 1'b0, RES_QUIET);
    for (int i = 0; i < HEAVY_ITEMS; i++) begin
      it = '{OP_ACCUM, 4'd7, VAL_EDGES[$urandom_range(0, 1)], 1'($urandom_range(0, 1))};
      drive_item(it, 1'b0, RES_QUIET);
    end
    drive_item('{OP_COUNT, 4'd7, 32'h0, 1'b0}, 1'b0, RES_QUIET);
    drive_item('{OP_LOAD, 4'd7, 32'($urandom), 1'b0}, 1'b0, RES_QUIET);
    for (int i = 0; i < 4; i++) begin
      it = '{OP_TERM, 4'd7, pick_value(4'd7), 1'(i == 3)};
      drive_item(it, 1'b0, RES_QUIET);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_regs(GAIN_SET[p], THRESH_SET[p]);
      drive_item('{OP_START, 4'd0, 32'($urandom), 1'($urandom_range(0, 1))}, 1'b0, RES_QUIET);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) drive_item(random_item(), 1'b0, RES_QUIET);
    end

    // one last setting with random register values
    drain();
    write_regs(32'($urandom), FIS_W'({$urandom, $urandom}) >> $urandom_range(0, 40));
    for (int i = 0; i < RANDOM_PER_PHASE; i++) drive_item(random_item(), 1'b0, RES_QUIET);

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ewc_fisher_penalty_engine_unit test passed");
    end else begin
      $display("ewc_fisher_penalty_engine_unit test failed");
    end
    $finish;
  end

endmodule
